FILE: hw/rtl/ifpc_pkg.sv
// ----------------------------------------------------------------------------
// ifpc_pkg
// shared types, constants and helper functions of the fuzzy increment controller
// ----------------------------------------------------------------------------
package ifpc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HALF_W   = 15;
  localparam int SCALE_W  = 13;
  localparam int LEVEL_W  = 24;
  localparam int ERR_W    = 18;
  localparam int DELTA_W  = 19;
  localparam int FZ_W     = 20;   // working width of the fuzzifier compares
  localparam int DIV_W    = 18;   // numerator / denominator width
  localparam int DIV_BITS = 12;   // quotient bits, Q0.12 membership
  localparam int CNT_W    = $clog2(DIV_BITS + 1);
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 24;
  localparam logic [SCALE_W-1:0] ONE_Q12 = SCALE_W'(4096);

  // register indexes
  localparam logic [CFG_IW-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ERR_HW     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DELTA_HW   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CSCALE     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LEVEL_NEG  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_LEVEL_ZERO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_LEVEL_POS  = 3'd6;

  typedef enum logic [1:0] {
    LVL_NEG  = 2'd0,
    LVL_ZERO = 2'd1,
    LVL_POS  = 2'd2
  } lvl_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic             div;   // weight comes from the divider
    logic             b;     // 0: N/Z pair, 1: Z/P pair
    logic [12:0]      h;     // upper-label weight when no division
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } fz_t;

  // pick the label pair and the interpolation terms
  function automatic fz_t fuzz(input logic signed [FZ_W-1:0] x,
                               input logic signed [FZ_W-1:0] w,
                               input logic signed [FZ_W-1:0] c);
    fz_t f;
    logic signed [FZ_W-1:0] lo_num, lo_den, hi_num, hi_den;
    lo_num = x + w;
    lo_den = c + w;
    hi_num = x - c;
    hi_den = w - c;
    f.div = 1'b0;
    f.b   = 1'b0;
    f.h   = 13'd0;
    f.num = '0;
    f.den = '0;
    if (x <= -w) begin
      f.h = 13'd0;
    end else if (x < c) begin
      f.div = 1'b1;
      f.num = lo_num[DIV_W-1:0];
      f.den = lo_den[DIV_W-1:0];
    end else if (x == c) begin
      f.h = ONE_Q12;
    end else if (x < w) begin
      f.div = 1'b1;
      f.b   = 1'b1;
      f.num = hi_num[DIV_W-1:0];
      f.den = hi_den[DIV_W-1:0];
    end else begin
      f.b = 1'b1;
      f.h = ONE_Q12;
    end
    return f;
  endfunction

  // rule table, row delta label, column error label
  function automatic lvl_t rule_lvl(input logic [1:0] d, input logic [1:0] e);
    lvl_t r;
    case (e)
      2'd0: r = LVL_NEG;
      2'd2: r = LVL_POS;
      default: begin
        case (d)
          2'd0:    r = LVL_NEG;
          2'd1:    r = LVL_ZERO;
          default: r = LVL_POS;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/ifpc_div.sv
// ----------------------------------------------------------------------------
// ifpc_div
// restoring divider, one quotient bit per cycle, gives floor((num << 12) / den)
// ----------------------------------------------------------------------------
module ifpc_div
  import ifpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]    rem_r, den_r, rem_nxt;
  logic [DIV_BITS-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [DIV_W:0]      r2;

  always_comb begin
    r2 = {rem_r, 1'b0};
    if (r2 >= {1'b0, den_r}) begin
      rem_nxt = DIV_W'(r2 - {1'b0, den_r});
      q_nxt   = {q_r[DIV_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = r2[DIV_W-1:0];
      q_nxt   = {q_r[DIV_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= CNT_W'(DIV_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

FILE: hw/rtl/incremental_fuzzy_pid_controller.sv
// ----------------------------------------------------------------------------
// incremental_fuzzy_pid_controller
// incremental fuzzy controller: error and error change fuzzified, rule outputs
// blended into an increment that is added to a saturating drive
// ----------------------------------------------------------------------------
// One sample word is taken at a time and one result word comes out for it.
// On the way from acceptance to a valid result, each membership whose value
// falls inside a slope goes through the shared bit-serial divider, one
// quotient bit per cycle, and the four rule terms are formed in turn, each
// a weight product and then a product with the selected level.
// A result waiting on out_ready does not stop the next sample from being
// accepted. Configuration words are written on the cfg channel, which is
// always ready; write them only while the block is idle.
module incremental_fuzzy_pid_controller
  import ifpc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [LEVEL_W-1:0]   out_drive,
  output logic signed [LEVEL_W-1:0]   out_increment,
  output logic                        out_saturated,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IW-1:0]           cfg_index,
  input  logic [CFG_DW-1:0]           cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CENTRE = 8'b0000_0010,
    S_EFUZ   = 8'b0000_0100,
    S_EDIV   = 8'b0000_1000,
    S_DFUZ   = 8'b0001_0000,
    S_DDIV   = 8'b0010_0000,
    S_MAC    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [SAMPLE_W-1:0] setpoint_r;
  logic [HALF_W-1:0]          err_hw_r, delta_hw_r;
  logic [SCALE_W-1:0]         cscale_r;
  logic signed [LEVEL_W-1:0]  lvl_neg_r, lvl_zero_r, lvl_pos_r;

  // controller state
  logic signed [ERR_W-1:0]    last_error_r;
  logic signed [LEVEL_W-1:0]  acc_drive_r;

  // per-word working registers
  logic signed [ERR_W-1:0]    error_r, centre_r;
  logic signed [DELTA_W-1:0]  delta_r;
  logic [12:0]                he_r, hd_r;
  logic                       eb_r, db_r;
  logic [1:0]                 step_r;
  logic                       phase_r;
  logic [25:0]                prod_r;
  logic signed [51:0]         acc_r;

  // output register
  logic                       out_valid_r;
  logic signed [LEVEL_W-1:0]  out_drive_r, out_inc_r;
  logic                       out_sat_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ifpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  wire   in_acc    = in_valid && in_ready;
  wire   load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // error of the incoming sample, full width
  wire signed [ERR_W-1:0] err_in = ERR_W'(setpoint_r) - ERR_W'(in_sample);

  // fuzzifier front ends, error around its centre, delta around zero
  fz_t fz_e, fz_d;
  always_comb begin
    fz_e = fuzz(FZ_W'(error_r), FZ_W'({1'b0, err_hw_r}), FZ_W'(centre_r));
    fz_d = fuzz(FZ_W'(delta_r), FZ_W'({1'b0, delta_hw_r}), FZ_W'(0));
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = fz_e.num;
    div_req.den   = fz_e.den;
    if (state_r == S_EFUZ) begin
      div_req.start = fz_e.div;
    end else if (state_r == S_DFUZ) begin
      div_req.start = fz_d.div;
      div_req.num   = fz_d.num;
      div_req.den   = fz_d.den;
    end
  end

  // centre = h * error, truncated toward zero, unless h is one
  logic [SCALE_W-1:0]      h_eff;
  logic [ERR_W-1:0]        mag;
  logic [29:0]             cprod;
  logic signed [ERR_W-1:0] centre_nxt;
  always_comb begin
    h_eff = (cscale_r > ONE_Q12) ? ONE_Q12 : cscale_r;
    mag   = error_r[ERR_W-1] ? ERR_W'(-error_r) : ERR_W'(error_r);
    cprod = 30'(mag[16:0]) * 30'(h_eff);
    if (h_eff == ONE_Q12) begin
      centre_nxt = '0;
    end else if (error_r[ERR_W-1]) begin
      centre_nxt = -$signed({1'b0, cprod[28:12]});
    end else begin
      centre_nxt = $signed({1'b0, cprod[28:12]});
    end
  end

  // rule term: weight pair product, then times the selected level
  logic [12:0]               me, md;
  lvl_t                      lsel;
  logic signed [LEVEL_W-1:0] lvl;
  logic signed [50:0]        term;
  always_comb begin
    me   = step_r[1] ? he_r : 13'(ONE_Q12 - he_r);
    md   = step_r[0] ? hd_r : 13'(ONE_Q12 - hd_r);
    lsel = rule_lvl(2'(db_r) + 2'(step_r[0]), 2'(eb_r) + 2'(step_r[1]));
    case (lsel)
      LVL_NEG:  lvl = lvl_neg_r;
      LVL_ZERO: lvl = lvl_zero_r;
      default:  lvl = lvl_pos_r;
    endcase
    term = 51'($signed({1'b0, prod_r})) * 51'(lvl);
  end

  // round half up to Q12.12, then saturating drive update
  logic signed [51:0]        rnd;
  logic signed [LEVEL_W-1:0] inc;
  logic signed [LEVEL_W:0]   nd;
  logic signed [LEVEL_W-1:0] drive_nxt;
  logic                      sat_nxt;
  always_comb begin
    rnd = acc_r + 52'sd8388608;
    inc = rnd[47:24];
    nd  = {acc_drive_r[LEVEL_W-1], acc_drive_r} + {inc[LEVEL_W-1], inc};
    if (nd[LEVEL_W] != nd[LEVEL_W-1]) begin
      sat_nxt   = 1'b1;
      drive_nxt = nd[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
    end else begin
      sat_nxt   = 1'b0;
      drive_nxt = nd[LEVEL_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_CENTRE;
      S_CENTRE: state_nxt = S_EFUZ;
      S_EFUZ:   state_nxt = fz_e.div ? S_EDIV : S_DFUZ;
      S_EDIV:   if (div_rsp.done) state_nxt = S_DFUZ;
      S_DFUZ:   state_nxt = fz_d.div ? S_DDIV : S_MAC;
      S_DDIV:   if (div_rsp.done) state_nxt = S_MAC;
      S_MAC:    if (phase_r && step_r == 2'd3) state_nxt = S_DONE;
      S_DONE:   if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_error_r <= '0;
      acc_drive_r  <= '0;
      setpoint_r   <= 16'sd4096;
      err_hw_r     <= 15'd4096;
      delta_hw_r   <= 15'd4096;
      cscale_r     <= ONE_Q12;
      lvl_neg_r    <= -24'sd40960;
      lvl_zero_r   <= '0;
      lvl_pos_r    <= 24'sd40960;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETPOINT:   setpoint_r <= cfg_data[SAMPLE_W-1:0];
          REG_ERR_HW:     err_hw_r   <= cfg_data[HALF_W-1:0];
          REG_DELTA_HW:   delta_hw_r <= cfg_data[HALF_W-1:0];
          REG_CSCALE:     cscale_r   <= cfg_data[SCALE_W-1:0];
          REG_LEVEL_NEG:  lvl_neg_r  <= cfg_data[LEVEL_W-1:0];
          REG_LEVEL_ZERO: lvl_zero_r <= cfg_data[LEVEL_W-1:0];
          REG_LEVEL_POS:  lvl_pos_r  <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // last error moves on as soon as the delta is captured
      if (in_acc) begin
        last_error_r <= err_in;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        acc_drive_r <= drive_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          error_r <= err_in;
          delta_r <= DELTA_W'(err_in) - DELTA_W'(last_error_r);
        end
      end
      S_CENTRE: centre_r <= centre_nxt;
      S_EFUZ: begin
        eb_r <= fz_e.b;
        he_r <= fz_e.h;
      end
      S_EDIV: if (div_rsp.done) he_r <= {1'b0, div_rsp.q};
      S_DFUZ: begin
        db_r    <= fz_d.b;
        hd_r    <= fz_d.h;
        step_r  <= '0;
        phase_r <= 1'b0;
        acc_r   <= '0;
      end
      S_DDIV: if (div_rsp.done) hd_r <= {1'b0, div_rsp.q};
      S_MAC: begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          prod_r <= 26'(me) * 26'(md);
        end else begin
          acc_r  <= acc_r + 52'(term);
          step_r <= step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_drive_r <= drive_nxt;
          out_inc_r   <= inc;
          out_sat_r   <= sat_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_increment = out_inc_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: hw/rtl/ifpc_checker.sv
// ----------------------------------------------------------------------------
// ifpc_checker
// port-level checks of the fuzzy increment controller
// ----------------------------------------------------------------------------
module ifpc_checker
  import ifpc_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [LEVEL_W-1:0]  out_drive,
  input logic                       out_saturated
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("result word changed while stalled");

  // one word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while busy");

  // clipping only lands on a range limit
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_drive == 24'sh7fffff) || (out_drive == 24'sh800000))
    else $error("saturated drive not at a limit");

  // no result shortly after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind incremental_fuzzy_pid_controller ifpc_checker u_ifpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_drive     (out_drive),
  .out_saturated (out_saturated)
);

FILE: tb/tb_incremental_fuzzy_pid_controller.sv
// ----------------------------------------------------------------------------
// tb_incremental_fuzzy_pid_controller
// self-checking bench: samples go in over valid/ready, every result word is
// compared with a predictor of the fuzzy increment and the saturating drive
// ----------------------------------------------------------------------------
module tb_incremental_fuzzy_pid_controller;
  import ifpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [LEVEL_W-1:0] drive;
    logic signed [LEVEL_W-1:0] increment;
    logic                      saturated;
  } ctl_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [LEVEL_W-1:0]  out_drive;
  logic signed [LEVEL_W-1:0]  out_increment;
  logic                       out_saturated;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IW-1:0]          cfg_index = '0;
  logic [CFG_DW-1:0]          cfg_data = '0;

  // register copies of the predictor
  longint set_pt, err_w, dlt_w, c_scale;
  longint lvl_val [3];
  // predictor state
  longint prev_err, drive_acc;

  logic [SAMPLE_W-1:0] sample_q [$];   // words waiting to be driven
  ctl_word_t           ctl_q [$];      // predicted result words
  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  bit  hold_samples = 1'b0;
  int  fail_count = 0;
  int  quiet_cycles = 0;

  // rule table, row delta label, column error label
  lvl_t rule_map [3][3] = '{'{LVL_NEG, LVL_NEG, LVL_POS},
                            '{LVL_NEG, LVL_ZERO, LVL_POS},
                            '{LVL_NEG, LVL_POS, LVL_POS}};

  incremental_fuzzy_pid_controller uut (.*);

  always #10 clk = ~clk;

  // ----- prediction -----
  // triangular memberships on -w, c, +w; weight of the upper label in hi
  function automatic void membership(input longint x, input longint w, input longint c,
                                     output int pair, output longint lo, output longint hi);
    if (x <= -w) begin
      hi = 0; pair = 0;
    end else if (x < c) begin
      hi = ((x + w) <<< 12) / (c + w); pair = 0;
    end else if (x == c) begin
      hi = 4096; pair = 0;
    end else if (x < w) begin
      hi = ((x - c) <<< 12) / (w - c); pair = 1;
    end else begin
      hi = 4096; pair = 1;
    end
    lo = 4096 - hi;
  endfunction

  function automatic ctl_word_t control_step(input logic signed [SAMPLE_W-1:0] smp);
    ctl_word_t r;
    longint err, dlt, h, ctr, mag, acc, inc, nd;
    longint we [2];
    longint wd [2];
    int eb, db;
    err = set_pt - longint'(smp);
    dlt = err - prev_err;
    h = (c_scale > 4096) ? 4096 : c_scale;
    ctr = 0;
    if (h != 4096) begin
      mag = (err < 0) ? -err : err;
      ctr = (mag * h) >>> 12;
      if (err < 0) ctr = -ctr;
    end
    membership(err, err_w, ctr, eb, we[0], we[1]);
    membership(dlt, dlt_w, 0, db, wd[0], wd[1]);
    acc = 0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        acc += we[i] * wd[j] * lvl_val[rule_map[db + j][eb + i]];
    // round half up, Q12.36 down to Q12.12
    inc = (acc + (64'sd1 <<< 23)) >>> 24;
    nd = drive_acc + inc;
    r.saturated = 1'b0;
    if (nd > 8388607) begin
      nd = 8388607; r.saturated = 1'b1;
    end
    if (nd < -8388608) begin
      nd = -8388608; r.saturated = 1'b1;
    end
    drive_acc = nd;
    prev_err = err;
    r.drive = nd[LEVEL_W-1:0];
    r.increment = inc[LEVEL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // ----- sample driver -----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      prev_err = 0;
      drive_acc = 0;
    end else begin
      if (in_valid && in_ready) begin
        // word accepted: predict its result and drop it from the queue
        ctl_q.push_back(control_step(in_sample));
        void'(sample_q.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the word until it is taken
      end else if (sample_q.size() > 0 && !hold_samples &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ----- config shadow: follow every register write -----
  always @(posedge clk) begin
    if (!rst_n) begin
      set_pt <= 4096; err_w <= 4096; dlt_w <= 4096; c_scale <= 4096;
      lvl_val[0] <= -40960; lvl_val[1] <= 0; lvl_val[2] <= 40960;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:   set_pt <= longint'($signed(cfg_data[15:0]));
        REG_ERR_HW:     err_w <= longint'(cfg_data[14:0]);
        REG_DELTA_HW:   dlt_w <= longint'(cfg_data[14:0]);
        REG_CSCALE:     c_scale <= longint'(cfg_data[12:0]);
        REG_LEVEL_NEG:  lvl_val[0] <= longint'($signed(cfg_data[23:0]));
        REG_LEVEL_ZERO: lvl_val[1] <= longint'($signed(cfg_data[23:0]));
        REG_LEVEL_POS:  lvl_val[2] <= longint'($signed(cfg_data[23:0]));
        default: ;
      endcase
    end
  end

  // ----- result monitor and checker -----
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (ctl_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        fail_count++;
      end else begin
        ctl_word_t w;
        w = ctl_q.pop_front();
        if (out_drive !== w.drive) report_mismatch("drive", out_drive, w.drive);
        if (out_increment !== w.increment)
          report_mismatch("increment", out_increment, w.increment);
        if (out_saturated !== w.saturated)
          report_mismatch("saturated", out_saturated, w.saturated);
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // ----- watchdog: cycles with no handshake on any channel -----
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ----- stimulus -----
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // writes all seven registers, then lets go of the channel
  task automatic write_all(input longint sp, input longint ew, input longint dw,
                           input longint cs, input longint ln, input longint lz,
                           input longint lp);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_ERR_HW, ew);
    write_reg(REG_DELTA_HW, dw);
    write_reg(REG_CSCALE, cs);
    write_reg(REG_LEVEL_NEG, ln);
    write_reg(REG_LEVEL_ZERO, lz);
    write_reg(REG_LEVEL_POS, lp);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block idle: nothing queued, nothing in flight, then a latency margin
  task automatic drain;
    wait (sample_q.size() == 0 && ctl_q.size() == 0 && !in_valid);
    repeat (45) @(posedge clk);
  endtask

  function automatic longint rand_level;
    case ($urandom_range(3))
      0: return -8388608;
      1: return 8388607;
      2: return longint'($signed(24'($urandom)));
      default: return longint'($urandom_range(200000)) - 100000;
    endcase
  endfunction

  function automatic longint rand_width;
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 32767;
      3: return $urandom_range(32767);
      default: return $urandom_range(8192, 256);
    endcase
  endfunction

  initial begin
    longint sp, ew;
    int v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, sample extremes, error at centre and breakpoints
    sample_q = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0,
                 16'sd8192, 16'sd0, 16'sd6144, 16'sd2048};
    drain();
    // scaled centre, scale above one, zero half width
    write_all(0, 0, 0, 2048, -40960, 4096, 40960);
    sample_q = '{16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sh7FFF};
    drain();
    write_all(-4096, 1000, 32767, 8191, -1, 0, 1);
    sample_q = '{16'sd0, -16'sd4096, -16'sd3096, 16'sd3000};
    drain();
    // drive clipped at both ends with extreme levels
    write_all(32767, 1, 1, 0, -8388608, 8388607, 8388607);
    sample_q = '{16'sh8000, 16'sh8000, 16'sh8000};
    drain();
    write_all(-32768, 1, 1, 4096, -8388608, -8388608, 8388607);
    sample_q = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    drain();

    // random phases: receiver idles, then sender idles, then no idling
    for (int ph = 0; ph < 10; ph++) begin
      sender_idle_pct   = (ph < 4) ? 9 : (ph < 7) ? 55 : 0;
      receiver_idle_pct = (ph < 4) ? 55 : (ph < 7) ? 9 : 0;
      sp = longint'($signed(16'($urandom)));
      ew = rand_width();
      if (ph == 0) sp = 32767;
      if (ph == 1) sp = -32768;
      write_all(sp, ew, rand_width(),
                (ph % 3 == 0) ? 4096 : (ph % 3 == 1) ? $urandom_range(8191) : 0,
                rand_level(), rand_level(), rand_level());
      for (int k = 0; k < 115; k++) begin
        if ($urandom_range(9) < 6) begin
          // near the setpoint so the slopes get used
          v = int'(sp) - $urandom_range(2 * ew + 2) + ew + 1;
          sample_q.push_back(v[SAMPLE_W-1:0]);
        end else begin
          sample_q.push_back(SAMPLE_W'($urandom));
        end
      end
      if (ph == 5) begin
        // stop sending halfway until every result is back
        wait (sample_q.size() < 60);
        hold_samples = 1'b1;
        wait (!in_valid && ctl_q.size() == 0);
        hold_samples = 1'b0;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ifpc_pkg.sv
hw/rtl/ifpc_div.sv
hw/rtl/incremental_fuzzy_pid_controller.sv
hw/rtl/ifpc_checker.sv
tb/tb_incremental_fuzzy_pid_controller.sv
